@@ hw/rtl/timing_wheel_scheduler_unit_macros.svh @@
// assertion macros for the timing wheel scheduler
`ifndef TIMING_WHEEL_SCHEDULER_UNIT_MACROS_SVH
`define TIMING_WHEEL_SCHEDULER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TWS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timing wheel check failed");
`define TWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timing wheel check failed");
`else
`define TWS_ASSERT_NOW(label, ante, cons)
`define TWS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/tws_pkg.sv @@
// package with sizes, codes and types of the timing wheel scheduler
`default_nettype none
package tws_pkg;
  localparam int SLOTS        = 64;
  localparam int POOL_ENTRIES = 32;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int ENTRY_W      = 6;
  localparam int POOL_IW      = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam logic [ENTRY_W-1:0] NIL = 6'd63;

  localparam logic ACT_SET  = 1'b0;
  localparam logic ACT_TICK = 1'b1;
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_FRD, S_FIRE, S_MRD, S_MWR
  } state_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [SLOT_W-1:0]  raddr;
  } slot_req_t;
endpackage
`default_nettype wire

@@ hw/rtl/tws_slot_ram.sv @@
// slot head memory with per-slot valid bits and registered read
`default_nettype none
module tws_slot_ram
  import tws_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire slot_req_t          req,
  output logic [ENTRY_W-1:0]      rdata
);
  logic [ENTRY_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]   valid;

  // storage write and read, old data on same-address access
  always_ff @(posedge clk) begin
    rdata <= valid[req.raddr] ? mem[req.raddr] : NIL;
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // valid bits, empty after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.waddr] <= 1'b1;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/timing_wheel_scheduler_unit.sv @@
// top level of the timing wheel scheduler: list sequencer and output register
// A set item gives one acknowledgement item. A tick item fires the entries of
// the current slot and then moves the pending entries onto the wheel. The
// sequencer fires one list entry per cycle while the output side does not
// stall, and each move needs a read and a write of the single-port slot head
// memory. The slot memory is empty right after reset through per-slot valid
// bits, so no clearing pass. No new item is taken while a tick is in progress.
`default_nettype none
`include "timing_wheel_scheduler_unit_macros.svh"
module timing_wheel_scheduler_unit
  import tws_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // delay_ticks[15:0], payload[47:16]
  input  wire logic        s_tuser,   // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // accepted[0], fired_payload[32:1], zero fill
  output logic             m_tuser,   // kind
  output logic             m_tlast
);
  state_t state, state_next;
  logic [ENTRY_W-1:0] entry_next [POOL_ENTRIES];
  logic [31:0]        entry_payload [POOL_ENTRIES];
  logic [15:0]        entry_delay [POOL_ENTRIES];
  logic [ENTRY_W-1:0] free_head, pending_head, cur;
  logic [SLOT_W-1:0]  pos, tgt;
  logic [ENTRY_W-1:0] rdata;
  slot_req_t          req;

  logic               out_free, emit, o_acc, o_kind, o_last;
  logic [31:0]        o_pay;
  logic               in_acc, cur_ok, fh_ok;
  logic [POOL_IW-1:0] ci, fi;
  logic [ENTRY_W-1:0] cur_nx;
  logic [SLOT_W:0]    tgt_sum;
  logic [SLOT_W-1:0]  tgt_calc, pos_inc;

  tws_slot_ram u_slot (.clk(clk), .rst(rst), .req(req), .rdata(rdata));

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign in_acc   = s_tvalid && s_tready;
  assign ci       = cur[POOL_IW-1:0];
  assign fi       = free_head[POOL_IW-1:0];
  assign cur_ok   = cur < ENTRY_W'(POOL_ENTRIES);
  assign fh_ok    = free_head < ENTRY_W'(POOL_ENTRIES);
  assign cur_nx   = entry_next[ci];
  assign pos_inc  = (pos == SLOT_W'(SLOTS - 1)) ? '0 : pos + 1'b1;

  // target slot of the pending entry at the walk pointer
  always_comb begin
    tgt_sum  = {1'b0, SLOT_W'(entry_delay[ci] % SLOTS)} + {1'b0, pos};
    tgt_calc = (tgt_sum >= (SLOT_W+1)'(SLOTS)) ? SLOT_W'(tgt_sum - (SLOT_W+1)'(SLOTS))
                                              : tgt_sum[SLOT_W-1:0];
  end

  // sequencer next state, slot memory requests and result selection
  always_comb begin
    state_next = state;
    req        = '{we: 1'b0, waddr: pos, wdata: NIL, raddr: pos};
    emit       = 1'b0;
    o_kind     = KIND_ACK;
    o_acc      = 1'b0;
    o_pay      = '0;
    o_last     = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (s_tuser == ACT_SET) begin
            emit  = 1'b1;
            o_acc = fh_ok;
          end else begin
            req.we     = 1'b1;
            state_next = S_FRD;
          end
        end
      end
      S_FRD: state_next = S_FIRE;
      S_FIRE: begin
        if (!cur_ok) begin
          state_next = S_MRD;
        end else if (out_free) begin
          emit   = 1'b1;
          o_kind = KIND_FIRE;
          o_acc  = 1'b1;
          o_pay  = entry_payload[ci];
          o_last = !(cur_nx < ENTRY_W'(POOL_ENTRIES));
        end
      end
      S_MRD: begin
        req.raddr = tgt_calc;
        state_next = cur_ok ? S_MWR : S_IDLE;
      end
      S_MWR: begin
        req.we     = 1'b1;
        req.waddr  = tgt;
        req.wdata  = cur;
        state_next = S_MRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // list control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head    <= '0;
      pending_head <= NIL;
      pos          <= '0;
      cur          <= NIL;
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        entry_next[i] <= (i + 1 < POOL_ENTRIES) ? ENTRY_W'(i + 1) : NIL;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && s_tuser == ACT_SET && fh_ok) begin
            free_head      <= entry_next[fi];
            entry_next[fi] <= pending_head;
            pending_head   <= free_head;
          end
        end
        S_FRD: cur <= rdata;
        S_FIRE: begin
          if (!cur_ok) begin
            pos <= pos_inc;
            cur <= pending_head;
          end else if (out_free) begin
            entry_next[ci] <= free_head;
            free_head      <= cur;
            cur            <= cur_nx;
          end
        end
        S_MRD: begin
          tgt <= tgt_calc;
          if (!cur_ok) begin
            pending_head <= NIL;
          end
        end
        S_MWR: begin
          entry_next[ci] <= rdata;
          cur            <= cur_nx;
        end
        default: ;
      endcase
    end
  end

  // entry payload and delay, written by a stored set
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc && s_tuser == ACT_SET && fh_ok) begin
      entry_delay[fi]   <= s_tdata[15:0];
      entry_payload[fi] <= s_tdata[47:16];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {7'd0, o_pay, o_acc};
      m_tuser <= o_kind;
      m_tlast <= o_last;
    end
  end

  `TWS_ASSERT_NOW(a_busy_not_ready, state != S_IDLE, !s_tready)
  `TWS_ASSERT_NOW(a_ack_is_last, m_tvalid && m_tuser == KIND_ACK, m_tlast)
  `TWS_ASSERT_NOW(a_free_head_ok, 1'b1, fh_ok || free_head == NIL)
  `TWS_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
`default_nettype wire

@@ tb/sv/timing_wheel_scheduler_unit_tb.sv @@
// testbench for the timing wheel scheduler: random set and tick items against a wheel predictor
`default_nettype none
module timing_wheel_scheduler_unit_tb
  import tws_pkg::*;
();

  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic [31:0] payload;
    logic        last;
  } wheel_result_t;

  // wheel predictor and queue of expected results
  class wheel_scoreboard;
    logic [ENTRY_W-1:0] slot_head [SLOTS];
    logic [ENTRY_W-1:0] entry_next [POOL_ENTRIES];
    logic [31:0]        entry_payload [POOL_ENTRIES];
    logic [15:0]        entry_delay [POOL_ENTRIES];
    logic [ENTRY_W-1:0] free_head;
    logic [ENTRY_W-1:0] pending_head;
    logic [SLOT_W-1:0]  position;
    wheel_result_t      expected_q [$];
    int                 errors;
    int                 fired_count;
    int                 rejected_count;
    int                 occupied;

    function new();
      for (int i = 0; i < SLOTS; i++) slot_head[i] = NIL;
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        entry_next[i] = (i + 1 < POOL_ENTRIES) ? ENTRY_W'(i + 1) : NIL;
        entry_payload[i] = '0;
        entry_delay[i] = '0;
      end
      free_head = '0;
      pending_head = NIL;
      position = '0;
      errors = 0;
      fired_count = 0;
      rejected_count = 0;
      occupied = 0;
    endfunction

    // apply one accepted input item to the predicted wheel
    function void note_item(logic action, logic [15:0] delay, logic [31:0] pay);
      logic [ENTRY_W-1:0] e;
      logic [ENTRY_W-1:0] nx;
      logic [SLOT_W-1:0]  tgt;
      int                 n;
      if (action == ACT_SET) begin
        e = free_head;
        if (e >= POOL_ENTRIES) begin
          expected_q.push_back('{KIND_ACK, 1'b0, 32'd0, 1'b1});
          rejected_count++;
          return;
        end
        free_head = entry_next[e];
        entry_payload[e] = pay;
        entry_delay[e] = delay;
        entry_next[e] = pending_head;
        pending_head = e;
        occupied++;
        expected_q.push_back('{KIND_ACK, 1'b1, 32'd0, 1'b1});
        return;
      end
      // fire the current slot
      e = slot_head[position];
      slot_head[position] = NIL;
      n = 0;
      while (n < POOL_ENTRIES && e < POOL_ENTRIES) begin
        nx = entry_next[e];
        expected_q.push_back('{KIND_FIRE, 1'b1, entry_payload[e], 1'b0});
        entry_next[e] = free_head;
        free_head = e;
        e = nx;
        n++;
      end
      if (n > 0) expected_q[$].last = 1'b1;
      fired_count += n;
      occupied -= n;
      position = position + 1'b1;
      // move pending entries onto the wheel
      e = pending_head;
      n = 0;
      while (n < POOL_ENTRIES && e < POOL_ENTRIES) begin
        nx = entry_next[e];
        tgt = entry_delay[e][SLOT_W-1:0] + position;
        entry_next[e] = slot_head[tgt];
        slot_head[tgt] = e;
        e = nx;
        n++;
      end
      pending_head = NIL;
    endfunction

    // compare one output item with the oldest expectation
    function void check_result(wheel_result_t got);
      wheel_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.kind !== exp_r.kind)
        $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
      if (got.accepted !== exp_r.accepted)
        $display("%0t: accepted expected %0d actual %0d", $time, exp_r.accepted,
                 got.accepted);
      if (got.payload !== exp_r.payload)
        $display("%0t: payload expected %h actual %h", $time, exp_r.payload,
                 got.payload);
      if (got.last !== exp_r.last)
        $display("%0t: last expected %0d actual %0d", $time, exp_r.last, got.last);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // delay_ticks[15:0], payload[47:16]
  logic        s_tuser;   // action
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // accepted[0], fired_payload[32:1], zero fill
  logic        m_tuser;   // kind
  logic        m_tlast;

  wheel_scoreboard wheel;
  int  send_idle_pct;
  int  recv_stall_pct;
  longint cycle_count;
  int  item_count;

  timing_wheel_scheduler_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: stall at random, check on handshake
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      wheel.check_result('{m_tuser, m_tdata[0], m_tdata[32:1], m_tlast});
  end
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // present one item, optionally after random idle cycles
  task automatic send_item(logic action, logic [15:0] delay, logic [31:0] pay);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= action;
    s_tdata <= {pay, delay};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    wheel.note_item(action, delay, pay);
    item_count++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (wheel.expected_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // random item: mostly sets while pool has room, ticks to drive firing
  task automatic send_random(int tick_pct);
    logic [15:0] d;
    case ($urandom_range(3))
      0: d = 16'($urandom_range(3));
      1: d = 16'($urandom_range(63));
      2: d = 16'($urandom);
      default: d = 16'($urandom_range(8)) + 16'd64 * 16'($urandom_range(1023));
    endcase
    send_item(($urandom_range(99) < tick_pct) ? ACT_TICK : ACT_SET, d, $urandom);
  endtask

  initial begin
    wheel = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = ACT_SET;
    m_tready = 1'b0;
    cycle_count = 0;
    item_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty tick, delay extremes, zero delay, pool exhaustion
    send_item(ACT_TICK, 16'd0, 32'd0);
    send_item(ACT_SET, 16'd0, 32'hFFFF_FFFF);
    send_item(ACT_SET, 16'hFFFF, 32'h0000_0000);
    send_item(ACT_SET, 16'd64, 32'hA5A5_5A5A);
    send_item(ACT_TICK, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(ACT_TICK, 16'd0, 32'd0);
    for (int i = 0; i < 14; i++) send_item(ACT_SET, 16'd1, 32'h1000_0000 + i);
    for (int i = 0; i < 20; i++) send_item(ACT_SET, 16'd2, $urandom);
    send_item(ACT_TICK, 16'd0, 32'd0);
    send_item(ACT_TICK, 16'd0, 32'd0);
    send_item(ACT_TICK, 16'd0, 32'd0);
    send_item(ACT_TICK, 16'd0, 32'd0);
    drain_results();

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int i = 0; i < 95; i++) send_random((wheel.occupied > 28) ? 60 : 30);
      // pause until everything is out
      drain_results();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();

    $display("%0d items sent, %0d timers fired, %0d sets rejected on a full pool",
             item_count, wheel.fired_count, wheel.rejected_count);
    if (wheel.errors == 0 && wheel.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
